// ----- sv/pvu_pkg.sv -----
// shared types, constants and functions of the peak-to-peak vu bar meter
// no dependencies; every other file of the block but pvu_ram imports this package
`default_nettype none

package pvu_pkg;

  localparam int unsigned SAMPLE_W          = 10;
  localparam int unsigned MIN_W             = 11;
  localparam int unsigned LEVEL_W           = 10;
  localparam int unsigned COL_W             = 3;
  localparam int unsigned LIT_W             = 4;
  localparam int unsigned COLOR_W           = 16;
  localparam int unsigned LED_COUNT         = 8;
  localparam int unsigned STEP_COUNT        = 7;
  localparam int unsigned MAX_RESULTS       = 8;
  localparam int unsigned COLUMN_COUNT_DEF  = 8;

  // apb side
  localparam int unsigned CFG_AW      = 5;
  localparam int unsigned CFG_DW      = 32;
  localparam int unsigned CFG_IDX_W   = 3;

  // window minimum before any sample
  localparam logic [MIN_W-1:0] NO_MIN = 11'd1024;

  // led colour codes
  localparam logic [1:0] COLOR_OFF    = 2'd0;
  localparam logic [1:0] COLOR_GREEN  = 2'd1;
  localparam logic [1:0] COLOR_YELLOW = 2'd2;
  localparam logic [1:0] COLOR_RED    = 2'd3;

  typedef logic [STEP_COUNT-1:0][LEVEL_W-1:0] step_arr_t;
  typedef logic [LED_COUNT-1:0][1:0]          color_arr_t;

  localparam step_arr_t STEP_RESET = {
    10'd425, 10'd360, 10'd295, 10'd230, 10'd195, 10'd130, 10'd65
  };

  localparam color_arr_t LED_COLOR = {
    COLOR_RED, COLOR_RED, COLOR_YELLOW, COLOR_YELLOW, COLOR_YELLOW,
    COLOR_GREEN, COLOR_GREEN, COLOR_GREEN
  };

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;        // input transfer this cycle
    logic rd;          // read the level store at the emit counter
    logic load;        // load the result register from the read data
    logic emit_clear;  // frame starts, emit counter back to column 0
    logic emit_next;   // result taken, move to the next column
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic frame_end;   // a window end now would fill the last column
    logic emit_last;   // emit counter sits on the final result of a frame
  } dp_stat_t;

  // one more than the highest-numbered step exceeded, at least one
  function automatic logic [LIT_W-1:0] lit_for_level(input logic [LEVEL_W-1:0] level,
                                                     input step_arr_t steps);
    logic [LIT_W-1:0] lit;
    lit = LIT_W'(1);
    for (int k = 0; k < STEP_COUNT; k++) begin
      if (level > steps[k]) begin
        lit = LIT_W'(k + 2);
      end
    end
    return lit;
  endfunction

  function automatic logic [COLOR_W-1:0] colors_for_lit(input logic [LIT_W-1:0] lit);
    logic [COLOR_W-1:0] bits;
    bits = '0;
    for (int i = 0; i < LED_COUNT; i++) begin
      if (LIT_W'(i) < lit) begin
        bits[2*i +: 2] = LED_COLOR[i];
      end
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

// ----- sv/pvu_in_if.sv -----
// sample channel: valid/ready handshake with microphone sample and window flag
// depends on pvu_pkg
`default_nettype none

interface pvu_in_if import pvu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] mic_sample;
  logic                window_end;

  modport source (output valid, output mic_sample, output window_end, input ready);
  modport sink   (input valid, input mic_sample, input window_end, output ready);
endinterface

`default_nettype wire

// ----- sv/pvu_out_if.sv -----
// column result channel: valid/ready handshake with one bar column per transfer
// depends on pvu_pkg
`default_nettype none

interface pvu_out_if import pvu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   column_index;
  logic [LIT_W-1:0]   lit_count;
  logic [COLOR_W-1:0] led_colors;
  logic               last_column;

  modport source (output valid, output column_index, output lit_count,
                  output led_colors, output last_column, input ready);
  modport sink   (input valid, input column_index, input lit_count,
                  input led_colors, input last_column, output ready);
endinterface

`default_nettype wire

// ----- sv/pvu_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module pvu_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/pvu_cfg_regs.sv -----
// apb register file for the seven level steps
// depends on pvu_pkg
`default_nettype none

module pvu_cfg_regs import pvu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output step_arr_t         steps
);

  step_arr_t            step_r;
  step_arr_t            step_nxt;
  logic [CFG_IDX_W-1:0] idx;
  logic                 idx_ok;

  assign idx    = paddr[CFG_AW-1:2];
  assign idx_ok = idx < CFG_IDX_W'(STEP_COUNT);
  assign pready = 1'b1;
  assign steps  = step_r;

  always_comb begin
    step_nxt = step_r;
    if (psel && penable && pwrite && idx_ok) begin
      step_nxt[idx] = pwdata[LEVEL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = CFG_DW'(step_r[idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pvu_datapath.sv -----
// window trackers, column level store, emit counter and result register
// depends on pvu_pkg and pvu_ram
`default_nettype none

module pvu_datapath import pvu_pkg::*; #(
  parameter int unsigned COLUMN_COUNT = COLUMN_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [SAMPLE_W-1:0] mic_sample,
  input  logic                window_end,
  input  step_arr_t           steps,
  output logic [COL_W-1:0]    column_index,
  output logic [LIT_W-1:0]    lit_count,
  output logic [COLOR_W-1:0]  led_colors,
  output logic                last_column
);

  localparam int unsigned PTR_W  = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
  localparam int unsigned N_RES  = (COLUMN_COUNT < MAX_RESULTS) ? COLUMN_COUNT : MAX_RESULTS;
  localparam int unsigned EMIT_W = (N_RES > 1) ? $clog2(N_RES) : 1;

  logic [SAMPLE_W-1:0] max_r, max_nxt, max_upd;
  logic [MIN_W-1:0]    min_r, min_nxt, min_upd;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic [EMIT_W-1:0]   emit_r, emit_nxt;
  logic [LEVEL_W-1:0]  level;
  logic [LEVEL_W-1:0]  rd_level;
  logic [LIT_W-1:0]    lit;
  logic                ptr_last;
  logic                emit_last;

  // both trackers see every sample, window end sample included
  assign max_upd = (mic_sample > max_r) ? mic_sample : max_r;
  assign min_upd = ({1'b0, mic_sample} < min_r) ? {1'b0, mic_sample} : min_r;

  always_comb begin
    if (min_upd >= NO_MIN || {1'b0, max_upd} < min_upd) begin
      level = '0;
    end else begin
      level = max_upd - min_upd[LEVEL_W-1:0];
    end
  end

  assign ptr_last  = ptr_r == PTR_W'(COLUMN_COUNT - 1);
  assign emit_last = emit_r == EMIT_W'(N_RES - 1);

  assign stat.frame_end = window_end && ptr_last;
  assign stat.emit_last = emit_last;

  always_comb begin
    max_nxt = max_r;
    min_nxt = min_r;
    ptr_nxt = ptr_r;
    if (cmd.take) begin
      if (window_end) begin
        max_nxt = '0;
        min_nxt = NO_MIN;
        ptr_nxt = ptr_last ? '0 : ptr_r + 1'b1;
      end else begin
        max_nxt = max_upd;
        min_nxt = min_upd;
      end
    end
  end

  always_comb begin
    emit_nxt = emit_r;
    if (cmd.emit_clear) begin
      emit_nxt = '0;
    end else if (cmd.emit_next) begin
      emit_nxt = emit_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= '0;
      min_r  <= NO_MIN;
      ptr_r  <= '0;
      emit_r <= '0;
    end else begin
      max_r  <= max_nxt;
      min_r  <= min_nxt;
      ptr_r  <= ptr_nxt;
      emit_r <= emit_nxt;
    end
  end

  pvu_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (COLUMN_COUNT)
  ) u_level_store (
    .clk   (clk),
    .we    (cmd.take && window_end),
    .waddr (ptr_r),
    .wdata (level),
    .re    (cmd.rd),
    .raddr (PTR_W'(emit_r)),
    .rdata (rd_level)
  );

  assign lit = lit_for_level(rd_level, steps);

  // result register, held while the sink stalls
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      column_index <= COL_W'(emit_r);
      lit_count    <= lit;
      led_colors   <= colors_for_lit(lit);
      last_column  <= emit_last;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pvu_ctrl.sv -----
// controller: sample intake, then one read-load-present round per column result
// depends on pvu_pkg
`default_nettype none

module pvu_ctrl import pvu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_LD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.take       = in_valid && in_ready;
    case (state_r)
      S_IDLE: begin
        if (cmd.take && stat.frame_end) begin
          cmd.emit_clear = 1'b1;
          state_nxt      = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LD;
      end
      S_LD: begin
        cmd.load  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (stat.emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/peak_to_peak_vu_bar_meter_core.sv -----
// top level of the peak-to-peak vu bar meter: apb registers, controller, datapath
// depends on pvu_pkg, pvu_in_if, pvu_out_if, pvu_cfg_regs, pvu_ctrl, pvu_datapath
//
//   channel   direction  handshake             payload
//   in_chan   sink       valid / ready         mic_sample[9:0], window_end
//   out_chan  source     valid / ready         column_index[2:0], lit_count[3:0],
//                                              led_colors[15:0], last_column
//   cfg_*     apb slave  psel/penable/pready   paddr[4:0], pwdata/prdata[31:0]
//
// a sample is taken every cycle while no frame is being sent
// the window end that fills the last column starts a frame of min(COLUMN_COUNT, 8)
// results; each goes through a level store read, a result load and presentation,
// held while the sink stalls, and the sample side is held off meanwhile
// reset (rst_n, synchronous) clears trackers, column pointer, state and the steps;
// the level store itself is not cleared
`default_nettype none

module peak_to_peak_vu_bar_meter_core import pvu_pkg::*; #(
  parameter int unsigned COLUMN_COUNT = COLUMN_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  pvu_in_if.sink            in_chan,
  pvu_out_if.source         out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  step_arr_t steps;
  dp_cmd_t   cmd;
  dp_stat_t  stat;

  // level steps, to be written only while the meter is idle; the block does not enforce it
  pvu_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .steps   (steps)
  );

  // sequencing of intake and the column burst
  pvu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // max/min tracking, level store and colour mapping
  pvu_datapath #(
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .mic_sample   (in_chan.mic_sample),
    .window_end   (in_chan.window_end),
    .steps        (steps),
    .column_index (out_chan.column_index),
    .lit_count    (out_chan.lit_count),
    .led_colors   (out_chan.led_colors),
    .last_column  (out_chan.last_column)
  );

  // the two sides never run at once
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("sample intake open while a column result is shown");

  // the final transfer of a frame reopens the intake
  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.ready && out_chan.last_column |=> in_chan.ready)
    else $error("intake not reopened after the last column");

  // the bottom led of every column is lit green
  a_bottom_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.led_colors[1:0] == COLOR_GREEN && out_chan.lit_count != '0))
    else $error("column result with no lit led");

  // a non-final transfer is followed by the next column once it is read and loaded
  a_column_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.ready && !out_chan.last_column |=>
      ##2 (out_chan.valid && out_chan.column_index == $past(out_chan.column_index, 3) + 3'd1))
    else $error("column results out of order");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// self-checking testbench of the peak-to-peak vu bar meter core
// needs pvu_pkg, pvu_in_if, pvu_out_if and peak_to_peak_vu_bar_meter_core;
// a directed table is followed by random windows under several threshold settings
`timescale 1ns / 1ps

module testbench import pvu_pkg::*;;

  localparam int unsigned COLUMNS        = COLUMN_COUNT_DEF;
  localparam int unsigned FRAME_LEN      = (COLUMNS < MAX_RESULTS) ? COLUMNS : MAX_RESULTS;
  localparam int unsigned SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int unsigned DIRECTED_ROWS  = 15;
  localparam int unsigned SETTINGS_COUNT = 6;
  localparam int unsigned PHASE_ITEMS    = 40;
  // time given to the block after the last owed column has arrived
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned QUIET_LIMIT    = 2000;

  // one column of the bar display as it leaves the block
  typedef struct {
    logic [COL_W-1:0]   column_index;
    logic [LIT_W-1:0]   lit_count;
    logic [COLOR_W-1:0] led_colors;
    logic               last_column;
  } bar_col_t;

  // want_lit of zero: the column is left to the meter model
  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                window_end;
    logic [LIT_W-1:0]    want_lit;
    logic [COLOR_W-1:0]  want_colors;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  pvu_in_if  in_chan ();
  pvu_out_if out_chan ();

  peak_to_peak_vu_bar_meter_core #(
    .COLUMN_COUNT(COLUMNS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // meter model: window trackers, stored levels and thresholds
  logic [SAMPLE_W-1:0] peak_hi;
  logic [MIN_W-1:0]    peak_lo;
  int unsigned         col_ptr;
  logic [LEVEL_W-1:0]  col_levels [COLUMNS];
  logic [LIT_W-1:0]    col_typed_lit [COLUMNS];
  logic [COLOR_W-1:0]  col_typed_colors [COLUMNS];
  logic [LEVEL_W-1:0]  step_regs [STEP_COUNT];

  // columns still owed by the block, oldest first
  bar_col_t pending_columns [$];

  int unsigned fault_count     = 0;
  int unsigned samples_sent    = 0;
  int unsigned columns_checked = 0;
  int unsigned reg_writes      = 0;

  // sender burst shaping
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  // long receiver hold-off, picked up by the sink process
  bit long_hold_req = 1'b0;

  stim_row_t directed_rows [DIRECTED_ROWS];

  function automatic logic [LIT_W-1:0] bar_lit(input logic [LEVEL_W-1:0] level);
    int unsigned lit;
    lit = 1;
    // thresholds need not be ordered: the highest-numbered one exceeded wins
    for (int k = 0; k < STEP_COUNT; k++) begin
      if (level > step_regs[k]) lit = k + 2;
    end
    return LIT_W'(lit);
  endfunction

  function automatic logic [COLOR_W-1:0] bar_colors(input logic [LIT_W-1:0] lit);
    logic [COLOR_W-1:0] bits;
    bits = '0;
    for (int i = 0; i < LED_COUNT; i++) begin
      if (i < lit) begin
        bits[2*i +: 2] = (i < 3) ? COLOR_GREEN : (i < 6) ? COLOR_YELLOW : COLOR_RED;
      end
    end
    return bits;
  endfunction

  function automatic void meter_clear();
    peak_hi = '0;
    peak_lo = NO_MIN;
    col_ptr = 0;
    for (int c = 0; c < COLUMNS; c++) begin
      col_levels[c]       = '0;
      col_typed_lit[c]    = '0;
      col_typed_colors[c] = '0;
    end
    for (int k = 0; k < STEP_COUNT; k++) step_regs[k] = STEP_RESET[k];
  endfunction

  // one accepted sample: update trackers; a window end closes the window, the last column emits a frame
  function automatic void meter_take(input logic [SAMPLE_W-1:0] s, input logic w,
                                     input logic [LIT_W-1:0] t_lit,
                                     input logic [COLOR_W-1:0] t_col);
    logic [LEVEL_W-1:0] lvl;
    bar_col_t           col;
    // the window's last sample counts towards max and min too
    if (s > peak_hi) peak_hi = s;
    if ({1'b0, s} < peak_lo) peak_lo = {1'b0, s};
    if (!w) return;
    if (peak_lo >= NO_MIN || {1'b0, peak_hi} < peak_lo) begin
      lvl = '0;
    end else begin
      lvl = LEVEL_W'({1'b0, peak_hi} - peak_lo);
    end
    peak_hi = '0;
    peak_lo = NO_MIN;
    col_levels[col_ptr]       = lvl;
    col_typed_lit[col_ptr]    = t_lit;
    col_typed_colors[col_ptr] = t_col;
    col_ptr++;
    if (col_ptr < COLUMNS) return;
    col_ptr = 0;
    for (int c = 0; c < FRAME_LEN; c++) begin
      col.column_index = COL_W'(c);
      if (col_typed_lit[c] != '0) begin
        col.lit_count  = col_typed_lit[c];
        col.led_colors = col_typed_colors[c];
      end else begin
        col.lit_count  = bar_lit(col_levels[c]);
        col.led_colors = bar_colors(col.lit_count);
      end
      col.last_column = (c + 1 == FRAME_LEN);
      pending_columns.push_back(col);
    end
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic w,
                             input logic [LIT_W-1:0] t_lit, input logic [COLOR_W-1:0] t_col);
    // valid drops at the step of the previous transfer, so never twice in one step
    if (gap_left > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_chan.valid      <= 1'b1;
    in_chan.mic_sample <= s;
    in_chan.window_end <= w;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    meter_take(s, w, t_lit, t_col);
    samples_sent++;
    if (burst_left <= 1) begin
      burst_left = $urandom_range(1, 30);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end else begin
      burst_left--;
    end
  endtask

  // sender rests until every owed column has arrived, then the block settles
  task automatic rest_and_drain();
    in_chan.valid <= 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input int unsigned idx, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(4 * idx);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    // indexes past the last threshold are ignored by the block
    if (idx < STEP_COUNT) step_regs[idx] = value[LEVEL_W-1:0];
    reg_writes++;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(input int unsigned idx);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_AW'(4 * idx);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== CFG_DW'(step_regs[idx])) begin
      $error("level_step[%0d]: expected %0d, got %0d", idx, step_regs[idx], cfg_prdata);
      fault_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // result side: checks every transfer, stalls on a rotating pattern and on a long hold when asked
  always @(posedge clk) begin : column_sink
    bar_col_t    want;
    logic [7:0]  ready_pattern;
    int unsigned pattern_age;
    int unsigned hold_left;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_columns.size() == 0) begin
        $error("column result with none expected: column_index %0d", out_chan.column_index);
        fault_count++;
      end else begin
        want = pending_columns.pop_front();
        columns_checked++;
        if (out_chan.column_index !== want.column_index) begin
          $error("column_index: expected %0d, got %0d", want.column_index,
                 out_chan.column_index);
          fault_count++;
        end
        if (out_chan.lit_count !== want.lit_count) begin
          $error("lit_count: expected %0d, got %0d", want.lit_count, out_chan.lit_count);
          fault_count++;
        end
        if (out_chan.led_colors !== want.led_colors) begin
          $error("led_colors: expected %h, got %h", want.led_colors, out_chan.led_colors);
          fault_count++;
        end
        if (out_chan.last_column !== want.last_column) begin
          $error("last_column: expected %0d, got %0d", want.last_column,
                 out_chan.last_column);
          fault_count++;
        end
      end
    end
    if (hold_left == 0 && long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    // a fresh pattern when the old one has aged out; all ones gives stretches without stalls
    if (pattern_age == 0) begin
      ready_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom());
      if (ready_pattern == 8'h00) ready_pattern = 8'h5A;
      pattern_age = 32;
    end
    pattern_age--;
    ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ready_pattern[0];
    end
  end

  // watchdog: cycles without any transfer or register access
  always @(posedge clk) begin : quiet_watch
    int unsigned quiet_cycles;
    if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) || cfg_psel === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: %0d quiet cycles, %0d columns owed", quiet_cycles,
               pending_columns.size());
      $display("testbench failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned         sent_in_phase;
    int unsigned         style;
    int unsigned         len;
    int unsigned         lo;
    int unsigned         span;
    bit                  hi_first;
    logic [SAMPLE_W-1:0] s;
    logic                w;
    logic [CFG_DW-1:0]   wdata;
    logic [LEVEL_W-1:0]  step;

    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.mic_sample <= '0;
    in_chan.window_end <= 1'b0;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= '0;
    cfg_pwdata         <= '0;

    // one frame at reset thresholds; typed columns are plain to read off
    directed_rows = '{
      '{10'd0,    1'b1, 4'd1, 16'h0001},  // single-sample window at zero
      '{10'd1023, 1'b0, 4'd0, 16'h0000},
      '{10'd0,    1'b1, 4'd8, 16'hFA95},  // full swing, closing sample sets the minimum
      '{10'd1023, 1'b1, 4'd1, 16'h0001},  // single sample at full scale
      '{10'd500,  1'b0, 4'd0, 16'h0000},
      '{10'd434,  1'b1, 4'd2, 16'h0005},  // one above step one
      '{10'd100,  1'b0, 4'd0, 16'h0000},
      '{10'd165,  1'b1, 4'd1, 16'h0001},  // equal to step one stays at one led
      '{10'd900,  1'b0, 4'd0, 16'h0000},  // falling window, max and min apart
      '{10'd600,  1'b1, 4'd0, 16'h0000},
      '{10'd1,    1'b0, 4'd0, 16'h0000},
      '{10'd1022, 1'b0, 4'd0, 16'h0000},
      '{10'd512,  1'b1, 4'd0, 16'h0000},
      '{10'd426,  1'b0, 4'd0, 16'h0000},
      '{10'd0,    1'b1, 4'd8, 16'hFA95}   // one above step seven lights all
    };

    meter_clear();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < STEP_COUNT; k++) cfg_read_check(k);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      push_sample(directed_rows[r].sample, directed_rows[r].window_end,
                  directed_rows[r].want_lit, directed_rows[r].want_colors);
    end
    rest_and_drain();

    // setting 0 keeps the reset thresholds; the others rewrite all seven
    for (int phase = 0; phase < SETTINGS_COUNT; phase++) begin
      if (phase != 0) begin
        for (int k = 0; k < STEP_COUNT; k++) begin
          case (phase)
            1:       step = '0;
            2:       step = LEVEL_W'(SAMPLE_MAX);
            3:       step = LEVEL_W'($urandom_range(0, SAMPLE_MAX));
            4:       step = STEP_RESET[STEP_COUNT-1-k];  // descending order
            default: step = LEVEL_W'(k * 140 + $urandom_range(0, 60));
          endcase
          wdata = $urandom();
          wdata[LEVEL_W-1:0] = step;
          cfg_write(k, wdata);
        end
        // a write past the last threshold must leave every threshold alone
        if (phase == 2) cfg_write(STEP_COUNT, $urandom());
        for (int k = 0; k < STEP_COUNT; k++) cfg_read_check(k);
      end
      // the sink holds off long enough for a frame to back up into the input
      if (phase == 3) long_hold_req = 1'b1;

      sent_in_phase = 0;
      while (sent_in_phase < PHASE_ITEMS) begin
        style    = $urandom_range(0, 9);
        len      = $urandom_range(1, 5);
        lo       = $urandom_range(0, SAMPLE_MAX);
        span     = $urandom_range(0, SAMPLE_MAX - lo);
        hi_first = $urandom_range(0, 1);
        for (int j = 0; j < len; j++) begin
          if (style < 7) begin
            // well-formed window: both ends of the band, filler inside it
            if (j == 0) s = SAMPLE_W'(hi_first ? lo + span : lo);
            else if (j == len - 1) s = SAMPLE_W'(hi_first ? lo : lo + span);
            else s = SAMPLE_W'(lo + $urandom_range(0, span));
            w = (j == len - 1);
          end else if (style < 9) begin
            case ($urandom_range(0, 2))
              0:       s = '0;
              1:       s = SAMPLE_W'(SAMPLE_MAX);
              default: s = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            endcase
            w = (j == len - 1);
          end else begin
            // noise: window ends fall anywhere
            s = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            w = ($urandom_range(0, 3) == 0);
          end
          push_sample(s, w, '0, '0);
          sent_in_phase++;
        end
      end
      rest_and_drain();
    end

    $display("covered %0d samples and %0d register writes over %0d threshold settings,",
             samples_sent, reg_writes, SETTINGS_COUNT);
    $display("with %0d column results checked field by field", columns_checked);
    if (fault_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
